// ----- rtl/cnvs_pkg.sv -----
// shared types and constants of the chinese number voice sequencer
// used by the front, fifo, back and top level modules
package cnvs_pkg;

    localparam int FifoDepth = 4;
    localparam int NumDigits = 10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FRAC = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    localparam logic [2:0] REG_DIGIT_ZERO = 3'd0;
    localparam logic [2:0] REG_TEN        = 3'd1;
    localparam logic [2:0] REG_HUNDRED    = 3'd2;
    localparam logic [2:0] REG_THOUSAND   = 3'd3;
    localparam logic [2:0] REG_WAN        = 3'd4;
    localparam logic [2:0] REG_YI         = 3'd5;
    localparam logic [2:0] REG_MINUS      = 3'd6;
    localparam logic [2:0] REG_POINT      = 3'd7;

    typedef enum logic [3:0] {
        TK_DIGIT    = 4'd0,
        TK_TEN      = 4'd1,
        TK_HUNDRED  = 4'd2,
        TK_THOUSAND = 4'd3,
        TK_WAN      = 4'd4,
        TK_YI       = 4'd5,
        TK_MINUS    = 4'd6,
        TK_POINT    = 4'd7,
        TK_ERR      = 4'd8,
        TK_END      = 4'd9
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    typedef struct packed {
        logic [15:0] digit_zero_id;
        logic [15:0] ten_unit_id;
        logic [15:0] hundred_unit_id;
        logic [15:0] thousand_unit_id;
        logic [15:0] wan_unit_id;
        logic [15:0] yi_unit_id;
        logic [15:0] minus_word_id;
        logic [15:0] point_word_id;
    } cfg_t;

endpackage

// ----- rtl/cnvs_front.sv -----
// front: accepts numbers, converts to decimal, walks the digits into word tokens
// depends on cnvs_pkg
module cnvs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    input  logic                 fifo_full,
    output logic                 push,
    output cnvs_pkg::token_t     push_tok
);
    import cnvs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CONV = 9'b000000010,
        S_SIGN = 9'b000000100,
        S_INT  = 9'b000001000,
        S_INTZ = 9'b000010000,
        S_PNT  = 9'b000100000,
        S_FRAC = 9'b001000000,
        S_ERR  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        PH_ZERO = 4'b0001,
        PH_DIG  = 4'b0010,
        PH_UNIT = 4'b0100,
        PH_GRP  = 4'b1000
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] mag_reg, mag_next;
    logic [3:0]  bcd_reg [NumDigits];
    logic [3:0]  bcd_next [NumDigits];
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  frac_reg, frac_next;
    logic        neg_reg, neg_next;
    logic [3:0]  pos_reg, pos_next;
    logic        said_reg, said_next;
    logic        grp_said_reg, grp_said_next;
    logic        pend_reg, pend_next;

    logic [31:0] raw;
    logic [3:0]  cur_d;
    logic [3:0]  ip;
    logic [3:0]  adj [NumDigits];

    assign raw      = s_tdata[31:0];
    assign cur_d    = bcd_reg[pos_reg];
    assign ip       = pos_reg - frac_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        frac_next     = frac_reg;
        neg_next      = neg_reg;
        pos_next      = pos_reg;
        said_next     = said_reg;
        grp_said_next = grp_said_reg;
        pend_next     = pend_reg;
        push          = 1'b0;
        push_tok      = '{kind: TK_DIGIT, digit: 4'd0};
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next  = raw[31];
                    mag_next  = raw[31] ? (32'd0 - raw) : raw;
                    frac_next = s_tdata[35:32];
                    cnt_next  = '0;
                    for (int i = 0; i < NumDigits; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                    state_next = (s_tdata[35:32] > 4'd9) ? S_ERR : S_CONV;
                end
            end
            S_CONV:
            begin
                // double dabble, one bit per cycle
                bcd_next[0] = {adj[0][2:0], mag_reg[31]};
                for (int i = 1; i < NumDigits; i++)
                begin
                    bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
                mag_next = {mag_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (!fifo_full)
                begin
                    push          = neg_reg;
                    push_tok.kind = TK_MINUS;
                    pos_next      = 4'd9;
                    phase_next    = PH_ZERO;
                    said_next     = 1'b0;
                    grp_said_next = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = S_INT;
                end
            end
            S_INT:
            begin
                if (!fifo_full)
                begin
                    case (phase_reg)
                        PH_ZERO:
                        begin
                            if (cur_d != 4'd0)
                            begin
                                push       = pend_reg;
                                phase_next = PH_DIG;
                            end
                            else
                            begin
                                if (said_reg)
                                begin
                                    pend_next = 1'b1;
                                end
                                phase_next = PH_GRP;
                            end
                        end
                        PH_DIG:
                        begin
                            // leading one before the tens word is dropped in the top group
                            push = !(!said_reg && ip[1:0] == 2'd1 && cur_d == 4'd1);
                            push_tok.digit = cur_d;
                            pend_next      = 1'b0;
                            said_next      = 1'b1;
                            grp_said_next  = 1'b1;
                            phase_next     = PH_UNIT;
                        end
                        PH_UNIT:
                        begin
                            push = (ip[1:0] != 2'd0);
                            case (ip[1:0])
                                2'd3:    push_tok.kind = TK_THOUSAND;
                                2'd2:    push_tok.kind = TK_HUNDRED;
                                default: push_tok.kind = TK_TEN;
                            endcase
                            phase_next = PH_GRP;
                        end
                        default:
                        begin
                            if (ip[1:0] == 2'd0)
                            begin
                                push          = grp_said_reg && (ip[3:2] != 2'd0);
                                push_tok.kind = (ip[3:2] == 2'd2) ? TK_YI : TK_WAN;
                                if (grp_said_reg)
                                begin
                                    pend_next = 1'b0;
                                end
                                grp_said_next = 1'b0;
                            end
                            phase_next = PH_ZERO;
                            if (pos_reg == frac_reg)
                            begin
                                state_next = S_INTZ;
                            end
                            else
                            begin
                                pos_next = pos_reg - 4'd1;
                            end
                        end
                    endcase
                end
            end
            S_INTZ:
            begin
                if (!fifo_full)
                begin
                    push       = !said_reg;
                    state_next = (frac_reg != 4'd0) ? S_PNT : S_FIN;
                end
            end
            S_PNT:
            begin
                if (!fifo_full)
                begin
                    push          = 1'b1;
                    push_tok.kind = TK_POINT;
                    pos_next      = frac_reg - 4'd1;
                    state_next    = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (!fifo_full)
                begin
                    push           = 1'b1;
                    push_tok.digit = cur_d;
                    pos_next       = pos_reg - 4'd1;
                    if (pos_reg == 4'd0)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ERR:
            begin
                if (!fifo_full)
                begin
                    push          = 1'b1;
                    push_tok.kind = TK_ERR;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!fifo_full)
                begin
                    push          = 1'b1;
                    push_tok.kind = TK_END;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_ZERO;
            cnt_reg      <= '0;
            said_reg     <= 1'b0;
            grp_said_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            said_reg     <= said_next;
            grp_said_reg <= grp_said_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        frac_reg <= frac_next;
        neg_reg  <= neg_next;
        pos_reg  <= pos_next;
    end

endmodule

// ----- rtl/cnvs_fifo.sv -----
// short token queue between front and back
// depends on cnvs_pkg
module cnvs_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cnvs_pkg::token_t     push_tok,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output cnvs_pkg::token_t     pop_tok
);
    import cnvs_pkg::*;

    localparam int PtrW = $clog2(FifoDepth);

    token_t          mem_reg [FifoDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0]   cnt_reg;

    assign full    = (cnt_reg == (PtrW+1)'(FifoDepth));
    assign empty   = (cnt_reg == '0);
    assign pop_tok = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_tok;
        end
    end

endmodule

// ----- rtl/cnvs_back.sv -----
// back: maps tokens to voice ids, holds one word back to find the last one
// depends on cnvs_pkg
module cnvs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cnvs_pkg::cfg_t       cfg,
    input  logic                 empty,
    input  cnvs_pkg::token_t     pop_tok,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // voice_id[15:0], status[17:16], zeros
    output logic                 m_tlast
);
    import cnvs_pkg::*;

    logic        pend_v_reg;
    logic [15:0] pend_id_reg;
    logic [1:0]  pend_st_reg;
    logic        out_v_reg;
    logic [15:0] out_id_reg;
    logic [1:0]  out_st_reg;
    logic        out_last_reg;
    logic [15:0] map_id;
    logic [1:0]  map_st;

    always_comb
    begin
        map_st = ST_OK;
        case (pop_tok.kind)
            TK_DIGIT:    map_id = cfg.digit_zero_id + {12'd0, pop_tok.digit};
            TK_TEN:      map_id = cfg.ten_unit_id;
            TK_HUNDRED:  map_id = cfg.hundred_unit_id;
            TK_THOUSAND: map_id = cfg.thousand_unit_id;
            TK_WAN:      map_id = cfg.wan_unit_id;
            TK_YI:       map_id = cfg.yi_unit_id;
            TK_MINUS:    map_id = cfg.minus_word_id;
            TK_POINT:    map_id = cfg.point_word_id;
            TK_ERR:
            begin
                map_id = 16'd0;
                map_st = ST_FRAC;
            end
            default:     map_id = 16'd0;
        endcase
    end

    assign pop      = !empty && (!out_v_reg || m_tready);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_st_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else if (pop)
        begin
            // the held word moves out; an end token leaves nothing held
            out_v_reg  <= pend_v_reg;
            pend_v_reg <= (pop_tok.kind != TK_END);
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_id_reg   <= pend_id_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= (pop_tok.kind == TK_END);
            if (pop_tok.kind != TK_END)
            begin
                pend_id_reg <= map_id;
                pend_st_reg <= map_st;
            end
        end
    end

endmodule

// ----- rtl/chinese_number_voice_sequencer.sv -----
// One number in, its Chinese reading out as voice ids, one word per item. The
// front takes an item when idle, converts it to decimal (one bit per cycle),
// then walks all ten digit positions: per integer digit a zero check, digit
// and unit steps if nonzero and a group step, per fraction digit one step. It
// takes no new item until its end token is queued and waits on a full 4-entry
// queue. The back emits one word per cycle while tokens wait and m_tready is
// high, and holds each word until the next token shows whether it is the last.
// Fraction counts above nine give one word with status 1. Write the
// configuration registers only while no item is in flight. Depends on cnvs_pkg.
module chinese_number_voice_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // signed_number[31:0], fraction_digits[35:32], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // voice_id[15:0], status[17:16], zeros
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import cnvs_pkg::*;

    cfg_t   cfg_reg;
    logic   push, full, pop, empty;
    token_t push_tok, pop_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{16'd300, 16'd310, 16'd311, 16'd312,
                         16'd313, 16'd314, 16'd315, 16'd316};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIGIT_ZERO: cfg_reg.digit_zero_id    <= cfg_wdata;
                REG_TEN:        cfg_reg.ten_unit_id      <= cfg_wdata;
                REG_HUNDRED:    cfg_reg.hundred_unit_id  <= cfg_wdata;
                REG_THOUSAND:   cfg_reg.thousand_unit_id <= cfg_wdata;
                REG_WAN:        cfg_reg.wan_unit_id      <= cfg_wdata;
                REG_YI:         cfg_reg.yi_unit_id       <= cfg_wdata;
                REG_MINUS:      cfg_reg.minus_word_id    <= cfg_wdata;
                REG_POINT:      cfg_reg.point_word_id    <= cfg_wdata;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    cnvs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .fifo_full(full),
        .push     (push),
        .push_tok (push_tok)
    );

    cnvs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_tok(push_tok),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .pop_tok (pop_tok)
    );

    cnvs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .empty   (empty),
        .pop_tok (pop_tok),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

`ifndef SYNTHESIS
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17:16] == ST_FRAC) |-> m_tlast)
        else $error("error word not marked last");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:16] == ST_OK || m_tdata[17:16] == ST_FRAC))
        else $error("unexpected status");
    a_err_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17:16] == ST_FRAC) |-> (m_tdata[15:0] == 16'd0))
        else $error("error word with nonzero id");
`endif

endmodule
